// ===== rtl/bst_pkg.sv =====
`timescale 1ns / 1ps

package bst_pkg;

  // Position counter width; positions saturate at all ones
  localparam int PosW  = 16;
  localparam int LenW  = 16;
  localparam int ValW  = 31;
  localparam int KindW = 5;

  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [LenW-1:0] LenMax = '1;
  localparam logic [ValW-1:0] ValMax = '1;

  // Result queue between the scanner and the output port
  localparam int QDepth = 3;
  localparam int QCntW  = 2;

  typedef enum logic [KindW-1:0] {
    K_BAD     = 5'd0,
    K_PLUS    = 5'd1,
    K_MINUS   = 5'd2,
    K_STAR    = 5'd3,
    K_SLASH   = 5'd4,
    K_LPAREN  = 5'd5,
    K_RPAREN  = 5'd6,
    K_LBRACE  = 5'd7,
    K_RBRACE  = 5'd8,
    K_BANG    = 5'd9,
    K_BANG_EQ = 5'd10,
    K_EQ      = 5'd11,
    K_EQ_EQ   = 5'd12,
    K_LT      = 5'd13,
    K_LT_EQ   = 5'd14,
    K_GT      = 5'd15,
    K_GT_EQ   = 5'd16,
    K_AND_AND = 5'd17,
    K_OR_OR   = 5'd18,
    K_EOF     = 5'd19,
    K_NUMBER  = 5'd20,
    K_SPACE   = 5'd21,
    K_IDENT   = 5'd22
  } token_kind_e;

  typedef enum logic [3:0] {
    M_IDLE,
    M_NUM,
    M_SPACE,
    M_IDENT,
    M_BANG,
    M_EQ,
    M_LT,
    M_GT,
    M_AMP,
    M_PIPE
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [KindW-1:0] token_kind;
    logic [15:0]      token_start;
    logic [LenW-1:0]  token_length;
    logic [ValW-1:0]  number_value;
    logic             number_overflow;
    logic             last_of_run;
  } out_beat_t;

  // Up to two tokens produced by one byte
  typedef struct packed {
    logic [1:0] cnt;
    out_beat_t  tok0;
    out_beat_t  tok1;
  } step_res_t;

endpackage

// ===== rtl/bst_scan.sv =====
`timescale 1ns / 1ps

module bst_scan import bst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_beat_t  item_i,
  output step_res_t res_o
);

  scan_mode_e      mode_q, mode_d;
  logic [PosW-1:0] begin_q, begin_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [ValW-1:0] acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic [LenW-1:0] run_q, run_d;

  logic [7:0]      c;
  logic            is_end, is_digit, is_alpha, is_sp_start, is_sp_cont;
  logic [3:0]      dig;
  logic [ValW+3:0] prod;
  logic            prod_ovf;
  logic [ValW-1:0] acc_add;
  logic [PosW-1:0] pos_inc;
  logic [LenW-1:0] run_inc;
  logic            pend_vld, pair_hit, cont, new_emit;
  token_kind_e     pend_kind, pair_kind, new_kind;
  scan_mode_e      new_mode;
  out_beat_t       pend_tok, pair_tok, new_tok, eof_tok;
  step_res_t       res;

  // Character classes
  assign c           = item_i.text_byte;
  assign is_end      = item_i.end_of_text | (c == 8'h00);
  assign is_digit    = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha    = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  assign is_sp_start = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  assign is_sp_cont  = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  assign dig         = c[3:0];

  // acc * 10 + digit, saturating
  assign prod     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (ValW+4)'(dig);
  assign prod_ovf = prod > (ValW+4)'(ValMax);
  assign acc_add  = prod_ovf ? ValMax : prod[ValW-1:0];

  assign pos_inc = (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);
  assign run_inc = (run_q == LenMax) ? run_q : run_q + LenW'(1);

  // Pending token kind and lookahead pair match
  always_comb begin
    pend_kind = K_BAD;
    pair_kind = K_BAD;
    pair_hit  = 1'b0;
    cont      = 1'b0;
    case (mode_q)
      M_NUM: begin
        pend_kind = K_NUMBER;
        cont      = is_digit;
      end
      M_SPACE: begin
        pend_kind = K_SPACE;
        cont      = is_sp_cont;
      end
      M_IDENT: begin
        pend_kind = K_IDENT;
        cont      = is_alpha;
      end
      M_BANG: begin
        pend_kind = K_BANG;
        pair_kind = K_BANG_EQ;
        pair_hit  = (c == 8'h3d);
      end
      M_EQ: begin
        pend_kind = K_EQ;
        pair_kind = K_EQ_EQ;
        pair_hit  = (c == 8'h3d);
      end
      M_LT: begin
        pend_kind = K_LT;
        pair_kind = K_LT_EQ;
        pair_hit  = (c == 8'h3d);
      end
      M_GT: begin
        pend_kind = K_GT;
        pair_kind = K_GT_EQ;
        pair_hit  = (c == 8'h3d);
      end
      M_AMP: begin
        pair_kind = K_AND_AND;
        pair_hit  = (c == 8'h26);
      end
      M_PIPE: begin
        pair_kind = K_OR_OR;
        pair_hit  = (c == 8'h7c);
      end
      default: ;
    endcase
  end

  // Token started by this byte
  always_comb begin
    new_emit = 1'b1;
    new_mode = M_IDLE;
    new_kind = K_BAD;
    case (c)
      8'h2b: new_kind = K_PLUS;
      8'h2d: new_kind = K_MINUS;
      8'h2a: new_kind = K_STAR;
      8'h2f: new_kind = K_SLASH;
      8'h28: new_kind = K_LPAREN;
      8'h29: new_kind = K_RPAREN;
      8'h7b: new_kind = K_LBRACE;
      8'h7d: new_kind = K_RBRACE;
      8'h21: begin new_emit = 1'b0; new_mode = M_BANG; end
      8'h3d: begin new_emit = 1'b0; new_mode = M_EQ;   end
      8'h3c: begin new_emit = 1'b0; new_mode = M_LT;   end
      8'h3e: begin new_emit = 1'b0; new_mode = M_GT;   end
      8'h26: begin new_emit = 1'b0; new_mode = M_AMP;  end
      8'h7c: begin new_emit = 1'b0; new_mode = M_PIPE; end
      default: begin
        if (is_digit) begin
          new_emit = 1'b0;
          new_mode = M_NUM;
        end else if (is_sp_start) begin
          new_emit = 1'b0;
          new_mode = M_SPACE;
        end else if (is_alpha) begin
          new_emit = 1'b0;
          new_mode = M_IDENT;
        end
      end
    endcase
  end

  // Candidate tokens
  always_comb begin
    pend_vld = (mode_q != M_IDLE);

    pend_tok                 = '0;
    pend_tok.token_kind      = pend_kind;
    pend_tok.token_start     = 16'(begin_q);
    pend_tok.token_length    = run_q;
    pend_tok.number_value    = (mode_q == M_NUM) ? acc_q : '0;
    pend_tok.number_overflow = (mode_q == M_NUM) ? ovf_q : 1'b0;

    pair_tok              = '0;
    pair_tok.token_kind   = pair_kind;
    pair_tok.token_start  = 16'(begin_q);
    pair_tok.token_length = run_inc;

    new_tok              = '0;
    new_tok.token_kind   = new_kind;
    new_tok.token_start  = 16'(pos_q);
    new_tok.token_length = LenW'(1);

    eof_tok             = '0;
    eof_tok.token_kind  = K_EOF;
    eof_tok.token_start = 16'(pos_q);
  end

  // Next state and results of one byte
  always_comb begin
    mode_d  = mode_q;
    begin_d = begin_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    run_d   = run_q;
    res     = '0;

    if (is_end) begin
      mode_d = M_IDLE;
      if (pend_vld) begin
        res.tok0 = pend_tok;
        res.tok1 = eof_tok;
        res.cnt  = 2'd2;
      end else begin
        res.tok0 = eof_tok;
        res.cnt  = 2'd1;
      end
    end else if (cont) begin
      run_d = run_inc;
      pos_d = pos_inc;
      if (mode_q == M_NUM) begin
        acc_d = acc_add;
        ovf_d = ovf_q | prod_ovf;
      end
    end else if (pair_hit) begin
      res.tok0 = pair_tok;
      res.cnt  = 2'd1;
      mode_d   = M_IDLE;
      pos_d    = pos_inc;
    end else begin
      pos_d  = pos_inc;
      mode_d = new_mode;
      if (!new_emit) begin
        begin_d = pos_q;
        run_d   = LenW'(1);
        acc_d   = (new_mode == M_NUM) ? ValW'(dig) : '0;
        ovf_d   = 1'b0;
      end
      if (pend_vld) begin
        res.tok0 = pend_tok;
        res.tok1 = new_tok;
        res.cnt  = new_emit ? 2'd2 : 2'd1;
      end else if (new_emit) begin
        res.tok0 = new_tok;
        res.cnt  = 2'd1;
      end
    end

    // Mark the last token of this byte
    if (res.cnt == 2'd1) res.tok0.last_of_run = 1'b1;
    if (res.cnt == 2'd2) res.tok1.last_of_run = 1'b1;
  end

  assign res_o = res;

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      begin_q <= '0;
      pos_q   <= '0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      run_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      run_q   <= run_d;
    end
  end

endmodule

// ===== rtl/byte_stream_tokenizer.sv =====
`timescale 1ns / 1ps
// Each result passes through the input register and then the result queue before it leaves.
// Throughput: one byte per cycle while the output is not stalled and each byte yields at most
// one token; a byte that closes a pending token and emits another holds back the next byte.
// Reset: asynchronous, active low; clears scanner state, position, the input valid flag
// and the result queue count, nothing pending; the held byte and queue entries keep their values.

module byte_stream_tokenizer import bst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic             in_vld_q, in_vld_d;
  in_beat_t         in_data_q;
  logic             in_acc, step, pop;
  step_res_t        res;
  logic [1:0]       push_n;
  logic [QCntW-1:0] cnt_q, cnt_d, wr_base;
  out_beat_t        q_q [QDepth];
  out_beat_t        q_d [QDepth];

  // Input register: a byte moves on once the queue has room for two tokens
  assign step       = in_vld_q && (cnt_q <= QCntW'(QDepth - 2));
  assign in_stall_o = in_vld_q && !step;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_acc || (in_vld_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_data_q <= in_data_i;
    end
  end

  bst_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_q),
    .res_o  (res)
  );

  // Result queue: head at entry 0, shifts down on each output beat
  assign pop     = (cnt_q != '0) && !out_stall_i;
  assign push_n  = step ? res.cnt : 2'd0;
  assign wr_base = cnt_q - QCntW'(pop);
  assign cnt_d   = wr_base + QCntW'(push_n);

  always_comb begin
    for (int i = 0; i < QDepth - 1; i++) begin
      q_d[i] = pop ? q_q[i+1] : q_q[i];
    end
    q_d[QDepth-1] = q_q[QDepth-1];
    for (int i = 0; i < QDepth; i++) begin
      if ((push_n != 2'd0) && (QCntW'(i) == wr_base)) q_d[i] = res.tok0;
      if ((push_n == 2'd2) && (QCntW'(i) == wr_base + QCntW'(1))) q_d[i] = res.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = q_q[0];

  // Two tokens from one byte: only the second closes the run
  a_two_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.cnt == 2'd2) |-> (!res.tok0.last_of_run && res.tok1.last_of_run))
    else $error("two-token byte marks the wrong last token");

  // A single token from one byte closes the run
  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.cnt == 2'd1) |-> res.tok0.last_of_run)
    else $error("single-token byte not marked last");

  // A stalled byte stays held in the input register
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (in_vld_q && $stable(in_data_q)))
    else $error("stalled byte lost from input register");

  // Queue never overfills
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> ({1'b0, wr_base} + {1'b0, QCntW'(push_n)} <= (QCntW+1)'(QDepth)))
    else $error("result queue overflow");

endmodule
